### design/i2cmbe_pkg.sv
package i2cmbe_pkg;

	// Command codes carried in the func field of a request.
	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_RESTART = 3'd2,
		CMD_WRITE   = 3'd3,
		CMD_READ    = 3'd4,
		CMD_STOP    = 3'd5
	} cmd_t;

	localparam int unsigned FUNC_W  = 3;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PHASE_W = 5;

	// Phase of the ACK slot with SCL high, at which byte transfers finish; a write samples the ACK there.
	localparam logic [PHASE_W-1:0] PHASE_ACK_HIGH = 5'd17;

	// Engine state carried from one tick to the next.
	typedef struct packed {
		logic               scl_drive;
		logic               sda_drive;
		cmd_t               cmd;
		logic [PHASE_W-1:0] phase;
		logic [BYTE_W-1:0]  shift;
		logic               ack_flag;
		logic               ack_choice;
		logic [BYTE_W-1:0]  tx_latch;
		logic [BYTE_W-1:0]  rx_hold;
	} eng_state_t;

	localparam eng_state_t ENG_STATE_RESET = '{
		scl_drive:  1'b1,
		sda_drive:  1'b1,
		cmd:        CMD_NONE,
		phase:      '0,
		shift:      '0,
		ack_flag:   1'b0,
		ack_choice: 1'b0,
		tx_latch:   '0,
		rx_hold:    '0
	};

	// One result of a tick.
	typedef struct packed {
		logic              scl_release;
		logic              sda_release;
		logic              ready_res;
		logic              cmd_done;
		logic [BYTE_W-1:0] rx_byte;
		logic              ack_seen;
		logic              cmd_rejected;
	} tick_res_t;

endpackage

### design/i2cmbe_ifs.sv
// Request channel: one half-period tick with its command and sampled SDA.
interface i2cmbe_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] data_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, output func, output data_byte, output send_ack,
		output sda_in, input ready);
	modport sink (input valid, input func, input data_byte, input send_ack,
		input sda_in, output ready);
endinterface

// Result channel: line states and status produced by one tick.
interface i2cmbe_res_if;
	logic       valid;
	logic       ready;
	logic       scl_release;
	logic       sda_release;
	logic       ready_res;
	logic       cmd_done;
	logic [7:0] rx_byte;
	logic       ack_seen;
	logic       cmd_rejected;

	modport source (output valid, output scl_release, output sda_release,
		output ready_res, output cmd_done, output rx_byte, output ack_seen,
		output cmd_rejected, input ready);
	modport sink (input valid, input scl_release, input sda_release,
		input ready_res, input cmd_done, input rx_byte, input ack_seen,
		input cmd_rejected, output ready);
endinterface

### design/i2cmbe_core.sv
// I2C master bit engine, one half SCL period per request.
// The req channel carries one tick: a command code (tick only, start,
// repeated start, write byte, read byte, stop), the byte to send, the
// ACK choice for a read and the SDA level sampled at the end of the tick.
// A command is taken only while the engine is idle; one that arrives while
// busy is dropped and flagged by cmd_rejected in that tick's result.
// The res channel returns exactly one result per request: the SCL and SDA
// release states for the tick, readiness, command completion, the last
// received byte and the last write ACK.
// The result is registered: a request accepted at one edge has its result
// valid after that edge. One request is taken per cycle while no result waits
// unread; the engine state advances in the same cycle the request is accepted.
// The result sits in an output register; a new request is taken while the
// receiver takes the previous result, and req.ready drops only while a
// result waits and res.ready is low.
// Reset releases both lines, returns the engine to idle and clears the
// received byte, the ACK flag and the result register valid.
module i2c_master_bit_engine_core (
	input logic    clk,
	input logic    arst_n,
	i2cmbe_req_if.sink   req,
	i2cmbe_res_if.source res
);
	import i2cmbe_pkg::*;

	eng_state_t state_q;
	eng_state_t state_nxt;
	tick_res_t  tick_res;
	tick_res_t  res_q;
	logic       res_valid_q;
	logic       req_take;

	// Accept while the output register is empty or being drained.
	assign req.ready = !res_valid_q || res.ready;
	assign req_take  = req.valid && req.ready;

	i2cmbe_step u_step (
		.cur       (state_q),
		.func      (req.func),
		.data_byte (req.data_byte),
		.send_ack  (req.send_ack),
		.sda_in    (req.sda_in),
		.nxt       (state_nxt),
		.res       (tick_res)
	);

	// Engine state advances once per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_STATE_RESET;
		end else if (req_take) begin
			state_q <= state_nxt;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req_take) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (req_take) begin
			res_q <= tick_res;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.scl_release  = res_q.scl_release;
	assign res.sda_release  = res_q.sda_release;
	assign res.ready_res    = res_q.ready_res;
	assign res.cmd_done     = res_q.cmd_done;
	assign res.rx_byte      = res_q.rx_byte;
	assign res.ack_seen     = res_q.ack_seen;
	assign res.cmd_rejected = res_q.cmd_rejected;

endmodule

### design/i2cmbe_step.sv
module i2cmbe_step (
	input  i2cmbe_pkg::eng_state_t        cur,
	input  logic [i2cmbe_pkg::FUNC_W-1:0] func,
	input  logic [i2cmbe_pkg::BYTE_W-1:0] data_byte,
	input  logic                          send_ack,
	input  logic                          sda_in,
	output i2cmbe_pkg::eng_state_t        nxt,
	output i2cmbe_pkg::tick_res_t         res
);
	import i2cmbe_pkg::*;

	logic               is_cmd;
	logic               rejected;
	logic               done;
	logic               scl_o;
	logic               sda_o;
	logic [PHASE_W-1:0] p;

	// Command acceptance, then one phase of the active command.
	always_comb begin
		nxt      = cur;
		rejected = 1'b0;
		done     = 1'b0;
		is_cmd   = (func >= CMD_START) && (func <= CMD_STOP);

		if (cur.cmd != CMD_NONE) begin
			rejected = is_cmd;
		end else if (is_cmd) begin
			nxt.cmd        = cmd_t'(func);
			nxt.phase      = '0;
			nxt.tx_latch   = data_byte;
			nxt.ack_choice = send_ack;
			if (func == CMD_READ) begin
				nxt.shift = '0;
			end
		end

		scl_o = cur.scl_drive;
		sda_o = cur.sda_drive;
		p     = nxt.phase;

		unique case (nxt.cmd)
			CMD_START: begin
				scl_o = 1'b1;
				sda_o = (p == '0);
				done  = (p >= PHASE_W'(1));
			end
			CMD_RESTART: begin
				scl_o = (p != '0);
				sda_o = (p < PHASE_W'(2));
				done  = (p >= PHASE_W'(2));
			end
			CMD_WRITE: begin
				scl_o = p[0];
				if (!p[4]) begin
					// Bit index counts down from the MSB, one bit per SCL period.
					sda_o = nxt.tx_latch[~p[3:1]];
				end else begin
					sda_o = 1'b1;
					if (p >= PHASE_ACK_HIGH) begin
						nxt.ack_flag = ~sda_in;
						done         = 1'b1;
					end
				end
			end
			CMD_READ: begin
				scl_o = p[0];
				if (!p[4]) begin
					sda_o = 1'b1;
					if (p[0]) begin
						nxt.shift = {nxt.shift[BYTE_W-2:0], sda_in};
					end
				end else begin
					sda_o = ~nxt.ack_choice;
					if (p >= PHASE_ACK_HIGH) begin
						nxt.rx_hold = nxt.shift;
						done        = 1'b1;
					end
				end
			end
			CMD_STOP: begin
				scl_o = (p != '0);
				sda_o = (p >= PHASE_W'(2));
				done  = (p >= PHASE_W'(2));
			end
			default: begin
			end
		endcase

		// Line levels persist; byte transfers park with SCL low and SDA free.
		if (nxt.cmd != CMD_NONE) begin
			nxt.scl_drive = scl_o;
			nxt.sda_drive = sda_o;
			if (done) begin
				if (nxt.cmd == CMD_WRITE || nxt.cmd == CMD_READ) begin
					nxt.scl_drive = 1'b0;
					nxt.sda_drive = 1'b1;
				end
				nxt.cmd   = CMD_NONE;
				nxt.phase = '0;
			end else begin
				nxt.phase = p + PHASE_W'(1);
			end
		end

		res.scl_release  = scl_o;
		res.sda_release  = sda_o;
		res.ready_res    = (nxt.cmd == CMD_NONE);
		res.cmd_done     = done;
		res.rx_byte      = nxt.rx_hold;
		res.ack_seen     = nxt.ack_flag;
		res.cmd_rejected = rejected;
	end

endmodule
